@@ src/otrl_pkg.sv @@
package otrl_pkg;

  localparam int DEPTH  = 4096;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SEQ_W  = 31;
  localparam int FILL_W = 13;

  localparam logic [1:0] CMD_LOG   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ST_LOGGED  = 3'd0;
  localparam logic [2:0] ST_DROPPED = 3'd1;
  localparam logic [2:0] ST_HIT     = 3'd2;
  localparam logic [2:0] ST_MISS    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  // first member sits in the top bits
  typedef struct packed {
    logic [SEQ_W-1:0]   want_seq;
    logic               time_suspended;
    logic [63:0]        time_stamp;
    logic signed [31:0] event_extra;
    logic signed [31:0] event_ident;
    logic signed [15:0] event_category;
    logic signed [15:0] event_type;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   overwritten;
    logic [SEQ_W-1:0]   total_logged;
    logic [FILL_W-1:0]  fill_count;
    logic [63:0]        rd_time;
    logic signed [31:0] rd_extra;
    logic signed [31:0] rd_ident;
    logic signed [15:0] rd_category;
    logic signed [15:0] rd_type;
    logic [SEQ_W-1:0]   got_seq;
  } out_item_t;

  typedef struct packed {
    logic [63:0] tstamp;
    logic [31:0] extra;
    logic [31:0] ident;
    logic [15:0] category;
    logic [15:0] etype;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_BASE,
    S_DIST,
    S_SEL,
    S_ADDR,
    S_RD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic base;
    logic delta;
    logic sel;
    logic addr;
    logic rd;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       out_free;
  } ctl_stat_t;

endpackage

@@ src/otrl_ctrl.sv @@
module otrl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  otrl_pkg::ctl_stat_t stat,
  output otrl_pkg::ctl_cmd_t  ctl
);

  otrl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= otrl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      otrl_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.capture = 1'b1;
          state_nxt   = otrl_pkg::S_EXEC;
        end
      end
      otrl_pkg::S_EXEC: begin
        // reads take the long path through the window math and the memory
        if (stat.cmd == otrl_pkg::CMD_READ) begin
          state_nxt = otrl_pkg::S_BASE;
        end else begin
          ctl.exec  = 1'b1;
          state_nxt = otrl_pkg::S_OUT;
        end
      end
      otrl_pkg::S_BASE: begin
        ctl.base  = 1'b1;
        state_nxt = otrl_pkg::S_DIST;
      end
      otrl_pkg::S_DIST: begin
        ctl.delta = 1'b1;
        state_nxt = otrl_pkg::S_SEL;
      end
      otrl_pkg::S_SEL: begin
        ctl.sel   = 1'b1;
        state_nxt = otrl_pkg::S_ADDR;
      end
      otrl_pkg::S_ADDR: begin
        ctl.addr  = 1'b1;
        state_nxt = otrl_pkg::S_RD;
      end
      otrl_pkg::S_RD: begin
        ctl.rd    = 1'b1;
        state_nxt = otrl_pkg::S_OUT;
      end
      otrl_pkg::S_OUT: begin
        if (stat.out_free) begin
          ctl.load  = 1'b1;
          state_nxt = otrl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = otrl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/otrl_dp.sv @@
module otrl_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  otrl_pkg::ctl_cmd_t  ctl,
  output otrl_pkg::ctl_stat_t stat,
  input  logic [1:0]          in_cmd,
  input  otrl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output otrl_pkg::out_item_t out_item
);

  localparam int IDX_W = otrl_pkg::IDX_W;
  localparam int CNT_W = otrl_pkg::CNT_W;
  localparam int SEQ_W = otrl_pkg::SEQ_W;

  otrl_pkg::entry_t mem [otrl_pkg::DEPTH];

  logic [1:0]          cmd_r;
  otrl_pkg::in_item_t  item_r;

  logic [IDX_W-1:0]    head_r, tail_r;
  logic [CNT_W-1:0]    held_r;
  logic [SEQ_W-1:0]    seq_r, lost_r;

  logic [SEQ_W-1:0]    base_r, dist_r, got_r;
  logic                below_r;
  logic [IDX_W-1:0]    dsel_r, addr_r;
  otrl_pkg::entry_t    rd_data_r;
  logic [2:0]          res_status_r;

  logic                out_valid_r;
  logic [2:0]          out_status_r;
  otrl_pkg::out_item_t out_item_r;

  logic                do_write;
  logic                full;
  logic                in_win;
  logic [IDX_W:0]      addr_sum;
  otrl_pkg::entry_t    wr_entry;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == IDX_W'(otrl_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign do_write = ctl.exec && (cmd_r == otrl_pkg::CMD_LOG) && !item_r.time_suspended;
  assign full     = (held_r == CNT_W'(otrl_pkg::DEPTH));
  assign in_win   = (dist_r < SEQ_W'(held_r));
  assign addr_sum = {1'b0, tail_r} + {1'b0, dsel_r};

  always_comb begin
    wr_entry.tstamp   = item_r.time_stamp;
    wr_entry.extra    = item_r.event_extra;
    wr_entry.ident    = item_r.event_ident;
    wr_entry.category = item_r.event_category;
    wr_entry.etype    = item_r.event_type;
  end

  // single write port at the head, registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[head_r] <= wr_entry;
    end
    if (ctl.rd) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r <= in_item;
    end
    if (ctl.base) begin
      base_r <= seq_r - SEQ_W'(held_r);
    end
    if (ctl.delta) begin
      dist_r  <= item_r.want_seq - base_r;
      below_r <= (item_r.want_seq < base_r);
    end
    if (ctl.sel) begin
      // below the oldest held entry clamps up to it
      got_r  <= in_win ? item_r.want_seq : base_r;
      dsel_r <= in_win ? dist_r[IDX_W-1:0] : '0;
    end
    if (ctl.addr) begin
      addr_r <= (addr_sum >= (IDX_W+1)'(otrl_pkg::DEPTH))
              ? IDX_W'(addr_sum - (IDX_W+1)'(otrl_pkg::DEPTH))
              : addr_sum[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r        <= otrl_pkg::CMD_LOG;
      head_r       <= '0;
      tail_r       <= '0;
      held_r       <= '0;
      seq_r        <= '0;
      lost_r       <= '0;
      res_status_r <= otrl_pkg::ST_MISS;
    end else begin
      if (ctl.capture) begin
        cmd_r <= in_cmd;
      end
      if (ctl.exec) begin
        unique case (cmd_r)
          otrl_pkg::CMD_LOG: begin
            if (item_r.time_suspended) begin
              res_status_r <= otrl_pkg::ST_DROPPED;
            end else begin
              head_r <= ring_next(head_r);
              seq_r  <= seq_r + 1'b1;
              if (full) begin
                tail_r <= ring_next(tail_r);
                lost_r <= lost_r + 1'b1;
              end else begin
                held_r <= held_r + 1'b1;
              end
              res_status_r <= otrl_pkg::ST_LOGGED;
            end
          end
          otrl_pkg::CMD_CLEAR: begin
            head_r       <= '0;
            tail_r       <= '0;
            held_r       <= '0;
            seq_r        <= '0;
            lost_r       <= '0;
            res_status_r <= otrl_pkg::ST_CLEARED;
          end
          default: begin
            res_status_r <= otrl_pkg::ST_MISS;
          end
        endcase
      end
      if (ctl.sel) begin
        res_status_r <= (in_win || (below_r && (held_r != '0)))
                      ? otrl_pkg::ST_HIT : otrl_pkg::ST_MISS;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_status_r             <= res_status_r;
      out_item_r.fill_count    <= otrl_pkg::FILL_W'(held_r);
      out_item_r.total_logged  <= seq_r;
      out_item_r.overwritten   <= lost_r;
      if ((res_status_r == otrl_pkg::ST_HIT) && (cmd_r == otrl_pkg::CMD_READ)) begin
        out_item_r.got_seq     <= got_r;
        out_item_r.rd_time     <= rd_data_r.tstamp;
        out_item_r.rd_extra    <= rd_data_r.extra;
        out_item_r.rd_ident    <= rd_data_r.ident;
        out_item_r.rd_category <= rd_data_r.category;
        out_item_r.rd_type     <= rd_data_r.etype;
      end else begin
        out_item_r.got_seq     <= '0;
        out_item_r.rd_time     <= '0;
        out_item_r.rd_extra    <= '0;
        out_item_r.rd_ident    <= '0;
        out_item_r.rd_category <= '0;
        out_item_r.rd_type     <= '0;
      end
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_item      = out_item_r;

endmodule

@@ src/overwriting_trace_ring_log.sv @@
// Overwriting trace ring: keeps the last 4096 trace entries in a single-port-write,
// registered-read memory. Each input word carries one command in in_tuser (log, read by
// sequence, clear) and gives exactly one result word, whose kind is in out_tuser. Items are
// handled one at a time by a controller stepping a datapath: a log, clear or unused command
// passes through decode/execute and output load, while a read steps through decode, window
// base, distance, clamp/select, ring address, memory read and output load. The next word is
// accepted the cycle after the result is loaded into the output register, even while that
// result still waits for out_tready. No clearing pass is needed after reset: only entries
// inside the held window are ever returned in a result word.
module overwriting_trace_ring_log (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // event_type, event_category, event_ident, event_extra, time_stamp,
  // time_suspended, want_seq
  input  logic [191:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // got_seq, rd_type, rd_category, rd_ident, rd_extra, rd_time, fill_count,
  // total_logged, overwritten, zero pad
  output logic [271:0] out_tdata,
  // status
  output logic [2:0]   out_tuser
);

  otrl_pkg::ctl_cmd_t  ctl;
  otrl_pkg::ctl_stat_t stat;
  otrl_pkg::out_item_t out_item;

  otrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  otrl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_cmd     (in_tuser),
    .in_item    (otrl_pkg::in_item_t'(in_tdata)),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_item   (out_item)
  );

  assign out_tdata = {6'd0, out_item};

endmodule
